// ----- rtl/core/tmh_pkg.sv -----
// shared types, constants and helpers for the timer min-heap block
package tmh_pkg;

   localparam int CAPACITY   = 32;
   localparam int ID_BITS    = 16;
   localparam int WAIT_BITS  = 24;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD,
      ST_CMATCH,
      ST_CSLOT,
      ST_CSEL,
      ST_CDEL,
      ST_TDEC,
      ST_TFIRE,
      ST_FINAL
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_TICK
   } cell_op_type;

   // one pending timer: remaining ms, due flag, id and its slot number
   typedef struct packed {
      logic                 due;
      logic [WAIT_BITS-1:0] rem;
      logic [ID_BITS-1:0]   id;
      logic [SLOT_BITS-1:0] slot;
   } entry_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type op;
      entry_type   ent;
   } cell_cmd_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [SLOT_BITS-1:0] lowest_one(input logic [CAPACITY-1:0] vec);
      logic [SLOT_BITS-1:0] idx;
      idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = SLOT_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- rtl/core/tmh_cell.sv -----
// one cell of the sorted timer row: holds an entry, inserts, shifts and counts down
module tmh_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  tmh_pkg::cell_cmd_type cmd,
   input  logic                  shift_en,
   input  logic                  left_valid,
   input  tmh_pkg::entry_type    left_ent,
   input  logic                  left_after,
   input  logic                  right_valid,
   input  tmh_pkg::entry_type    right_ent,
   output logic                  valid_out,
   output tmh_pkg::entry_type    ent_out,
   output logic                  after_out
);
   import tmh_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type ent_ff;
   entry_type ent_in;

   // new entry goes behind this one when this one is due no later
   assign after_out = valid_ff && (ent_ff.rem <= cmd.ent.rem);
   assign valid_out = valid_ff;
   assign ent_out   = ent_ff;

   // next contents of the cell
   always_comb begin
      valid_in = valid_ff;
      ent_in   = ent_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!after_out) begin
               if (left_after) begin
                  valid_in = 1'b1;
                  ent_in   = cmd.ent;
               end else begin
                  valid_in = left_valid;
                  ent_in   = left_ent;
               end
            end
         end
         CELL_SHIFT: begin
            if (shift_en) begin
               valid_in = right_valid;
               ent_in   = right_ent;
            end
         end
         CELL_TICK: begin
            ent_in.due = (ent_ff.rem < WAIT_BITS'(2));
            ent_in.rem = (ent_ff.rem == '0) ? '0 : ent_ff.rem - WAIT_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

endmodule

// ----- rtl/core/timer_min_heap_lazy_cancel.sv -----
// timer table top level: sorted row of cells plus command sequencer
//
// Holds up to CAPACITY pending timers in a row of cells kept sorted by time
// remaining, earliest at the head and older first on ties. A request is taken
// when start is high and busy is low; every request gives one final response
// (rsp_last high), and a tick first gives one fired response per expired
// timer, earliest first. Responses appear on the rsp_ ports for one cycle,
// marked by rsp_valid, and cannot be held off. Before the final response, an
// add passes an add step, a cancel its match, slot resolve, select and delete
// stages (no delete for an unknown id), and a tick a decrement step and then
// the head cell pops one timer a cycle; any other kind goes straight to the
// final step. busy falls in the cycle the final response is shown, so a new
// request may be taken there. There is no clearing pass after reset.
module timer_min_heap_lazy_cancel (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_kind,
   input  logic [tmh_pkg::WAIT_BITS-1:0] req_timeout,
   input  logic [tmh_pkg::ID_BITS-1:0]  req_cancel_id,
   output logic                         rsp_valid,
   output logic                         rsp_fired,
   output logic [tmh_pkg::ID_BITS-1:0]  rsp_result_id,
   output logic [1:0]                   rsp_status,
   output logic signed [tmh_pkg::WAIT_BITS:0] rsp_next_timeout,
   output logic                         rsp_last
);
   import tmh_pkg::*;

   state_type               state_ff, state_in;
   logic [ID_BITS-1:0]      id_ctr_ff, id_ctr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [CAPACITY-1:0]     slot_used_ff, slot_used_in;
   logic [WAIT_BITS-1:0]    timeout_ff, timeout_in;
   logic [ID_BITS-1:0]      cancel_id_ff, cancel_id_in;
   logic [CAPACITY-1:0]     match_ff, match_in;
   logic [CAPACITY-1:0]     hit_slot_ff, hit_slot_in;
   logic [CAPACITY-1:0]     sel_ff, sel_in;
   logic [SLOT_BITS-1:0]    sel_slot_ff, sel_slot_in;
   logic [ID_BITS-1:0]      res_id_ff, res_id_in;
   status_type              res_status_ff, res_status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_fired_ff, rsp_fired_in;
   logic [ID_BITS-1:0]      rsp_id_ff, rsp_id_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [WAIT_BITS:0]      rsp_next_ff, rsp_next_in;
   logic                    rsp_last_ff, rsp_last_in;

   cell_cmd_type            cmd;
   logic [CAPACITY-1:0]     shift_en;
   logic [CAPACITY-1:0]     cell_valid;
   entry_type               cell_ent   [CAPACITY];
   logic [CAPACITY-1:0]     cell_after;
   logic [SLOT_BITS-1:0]    free_slot;
   logic [SLOT_BITS-1:0]    low_hit;
   logic [CAPACITY-1:0]     del_mask;
   logic [WAIT_BITS:0]      head_wait;
   logic                    accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // row of cells, each linked to both neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      lv, la, rv;
      entry_type le, re;
      if (i == 0) begin : g_head
         assign lv = 1'b0;
         assign le = '0;
         assign la = 1'b1;
      end else begin : g_mid
         assign lv = cell_valid[i-1];
         assign le = cell_ent[i-1];
         assign la = cell_after[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign rv = 1'b0;
         assign re = '0;
      end else begin : g_body
         assign rv = cell_valid[i+1];
         assign re = cell_ent[i+1];
      end
      tmh_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .shift_en    (shift_en[i]),
         .left_valid  (lv),
         .left_ent    (le),
         .left_after  (la),
         .right_valid (rv),
         .right_ent   (re),
         .valid_out   (cell_valid[i]),
         .ent_out     (cell_ent[i]),
         .after_out   (cell_after[i])
      );
   end

   // lowest free slot for a new timer
   assign free_slot = lowest_one(~slot_used_ff);

   // wait to the head timer, or minus one when the table is empty
   assign head_wait = cell_valid[0] ? {1'b0, cell_ent[0].rem} : '1;

   // cancel: slots that hold a matching id
   always_comb begin
      hit_slot_in = '0;
      for (int s = 0; s < CAPACITY; s++) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (match_ff[i] && (cell_ent[i].slot == SLOT_BITS'(s))) begin
               hit_slot_in[s] = 1'b1;
            end
         end
      end
   end

   // cancel: the matching cell with the lowest slot number
   assign low_hit = lowest_one(hit_slot_ff);
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         sel_in[i]   = match_ff[i] && (cell_ent[i].slot == low_hit);
         match_in[i] = cell_valid[i] && (cell_ent[i].id == cancel_id_ff);
      end
   end

   // cells at and behind the removed one move up
   always_comb begin
      del_mask[0] = sel_ff[0];
      for (int i = 1; i < CAPACITY; i++) begin
         del_mask[i] = del_mask[i-1] | sel_ff[i];
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      id_ctr_in      = id_ctr_ff;
      count_in       = count_ff;
      slot_used_in   = slot_used_ff;
      timeout_in     = timeout_ff;
      cancel_id_in   = cancel_id_ff;
      sel_slot_in    = sel_slot_ff;
      res_id_in      = res_id_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = 1'b0;
      rsp_fired_in   = rsp_fired_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_next_in    = rsp_next_ff;
      rsp_last_in    = rsp_last_ff;
      cmd.op         = CELL_HOLD;
      cmd.ent.due    = 1'b0;
      cmd.ent.rem    = timeout_ff;
      cmd.ent.id     = id_ctr_ff;
      cmd.ent.slot   = free_slot;
      shift_en       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               timeout_in    = req_timeout;
               cancel_id_in  = req_cancel_id;
               res_id_in     = '0;
               res_status_in = STATUS_OK;
               unique case (req_kind)
                  KIND_ADD:    state_in = ST_ADD;
                  KIND_CANCEL: state_in = ST_CMATCH;
                  KIND_TICK:   state_in = ST_TDEC;
                  default:     state_in = ST_FINAL;
               endcase
            end
         end
         ST_ADD: begin
            if (count_ff == COUNT_BITS'(CAPACITY)) begin
               res_status_in = STATUS_FULL;
            end else begin
               cmd.op                  = CELL_INSERT;
               slot_used_in[free_slot] = 1'b1;
               count_in                = count_ff + COUNT_BITS'(1);
               id_ctr_in               = id_ctr_ff + ID_BITS'(1);
               res_id_in               = id_ctr_ff;
            end
            state_in = ST_FINAL;
         end
         ST_CMATCH: begin
            state_in = ST_CSLOT;
         end
         ST_CSLOT: begin
            state_in = ST_CSEL;
         end
         ST_CSEL: begin
            sel_slot_in = low_hit;
            if (hit_slot_ff == '0) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_FINAL;
            end else begin
               state_in = ST_CDEL;
            end
         end
         ST_CDEL: begin
            cmd.op                    = CELL_SHIFT;
            shift_en                  = del_mask;
            slot_used_in[sel_slot_ff] = 1'b0;
            count_in                  = count_ff - COUNT_BITS'(1);
            state_in                  = ST_FINAL;
         end
         ST_TDEC: begin
            cmd.op   = CELL_TICK;
            state_in = ST_TFIRE;
         end
         ST_TFIRE: begin
            if (cell_valid[0] && cell_ent[0].due) begin
               cmd.op                         = CELL_SHIFT;
               shift_en                       = '1;
               slot_used_in[cell_ent[0].slot] = 1'b0;
               count_in                       = count_ff - COUNT_BITS'(1);
               rsp_valid_in                   = 1'b1;
               rsp_fired_in                   = 1'b1;
               rsp_id_in                      = cell_ent[0].id;
               rsp_status_in                  = STATUS_OK;
               rsp_next_in                    = '0;
               rsp_last_in                    = 1'b0;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            rsp_valid_in  = 1'b1;
            rsp_fired_in  = 1'b0;
            rsp_id_in     = res_id_ff;
            rsp_status_in = res_status_ff;
            rsp_next_in   = head_wait;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         id_ctr_ff    <= '0;
         count_ff     <= '0;
         slot_used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         id_ctr_ff    <= id_ctr_in;
         count_ff     <= count_in;
         slot_used_ff <= slot_used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload registers
   always_ff @(posedge clock) begin
      timeout_ff    <= timeout_in;
      cancel_id_ff  <= cancel_id_in;
      match_ff      <= match_in;
      hit_slot_ff   <= hit_slot_in;
      sel_ff        <= sel_in;
      sel_slot_ff   <= sel_slot_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // response ports
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fired        = rsp_fired_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_next_timeout = signed'(rsp_next_ff);
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_slot_count : assert property (@(posedge clock) disable iff (reset)
      $countones(slot_used_ff) == int'(count_ff))
      else $error("slot map and entry count disagree");

   a_cell_count : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("occupied cells and entry count disagree");

   a_head_packed : assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("head cell empty while timers are pending");

   a_last_frees : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy || $past(start && !busy))
      else $error("sequencer still busy after the final response");

   a_no_early_rsp : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> !rsp_valid)
      else $error("response in the cycle after a request was taken");
`endif

endmodule

// ----- test/tb_timer_min_heap_lazy_cancel.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the timer table: predicts each response and checks them in order
module tb_timer_min_heap_lazy_cancel;
   import tmh_pkg::*;

   localparam logic [1:0]           KIND_UNUSED     = 2'd3;
   localparam logic [WAIT_BITS-1:0] MAX_TIMEOUT     = '1;
   localparam int                   RUN_LIMIT       = 100_000;
   localparam int                   RANDOM_REQUESTS = 110;
   localparam int                   DRAIN_CYCLES    = 40;
   localparam int                   REPORT_LIMIT    = 10;

   // one response as the block should show it
   typedef struct {
      logic                        fired;
      logic [ID_BITS-1:0]          id;
      status_type                  status;
      logic signed [WAIT_BITS:0]   next_timeout;
      logic                        last;
   } timer_response_type;

   // tracks the timer table and the responses still owed by the block
   class timer_scoreboard_type;
      logic [31:0]         deadline [CAPACITY];
      logic [ID_BITS-1:0]  tmr_id [CAPACITY];
      logic [31:0]         order [CAPACITY];
      bit                  live [CAPACITY];
      logic [31:0]         now_ms;
      logic [ID_BITS-1:0]  id_next;
      logic [31:0]         seq_next;
      int                  count;
      int                  error_count;
      timer_response_type  pending_responses [$];

      function new();
         foreach (live[i]) live[i] = 1'b0;
         now_ms      = '0;
         id_next     = '0;
         seq_next    = '0;
         count       = 0;
         error_count = 0;
      endfunction

      // live slot due first, older timer first on equal deadlines; -1 when empty
      function int earliest_slot();
         int          best;
         logic [31:0] key_s, key_b, age_s, age_b;
         best = -1;
         for (int s = 0; s < CAPACITY; s++) begin
            if (live[s]) begin
               if (best < 0) begin
                  best = s;
               end else begin
                  key_s = (deadline[s] - now_ms) ^ 32'h8000_0000;
                  key_b = (deadline[best] - now_ms) ^ 32'h8000_0000;
                  age_s = seq_next - order[s];
                  age_b = seq_next - order[best];
                  if (key_s < key_b || (key_s == key_b && age_s > age_b)) best = s;
               end
            end
         end
         return best;
      endfunction

      // ms until the earliest deadline, clamped, or -1 for an empty table
      function logic signed [WAIT_BITS:0] wait_to_next();
         int          s;
         logic [31:0] d;
         s = earliest_slot();
         if (s < 0) return '1;
         d = deadline[s] - now_ms;
         if (d == 0 || d[31]) return '0;
         if (d > {8'd0, MAX_TIMEOUT}) return {1'b0, MAX_TIMEOUT};
         return {1'b0, d[WAIT_BITS-1:0]};
      endfunction

      function void queue_response(logic fired, logic [ID_BITS-1:0] id, status_type status,
                                   logic signed [WAIT_BITS:0] wait_ms, logic last);
         timer_response_type r;
         r.fired        = fired;
         r.id           = id;
         r.status       = status;
         r.next_timeout = wait_ms;
         r.last         = last;
         pending_responses.push_back(r);
      endfunction

      // apply one accepted request to the table and queue what it should produce
      function void note_request(logic [1:0] kind, logic [WAIT_BITS-1:0] timeout,
                                 logic [ID_BITS-1:0] cancel_id);
         int          slot;
         logic [31:0] d;
         slot = -1;
         case (kind)
            KIND_ADD: begin
               for (int s = 0; s < CAPACITY && slot < 0; s++) if (!live[s]) slot = s;
               if (slot < 0 || count >= CAPACITY) begin
                  queue_response(1'b0, '0, STATUS_FULL, wait_to_next(), 1'b1);
               end else begin
                  deadline[slot] = now_ms + {8'd0, timeout};
                  tmr_id[slot]   = id_next;
                  order[slot]    = seq_next;
                  live[slot]     = 1'b1;
                  seq_next++;
                  count++;
                  queue_response(1'b0, id_next, STATUS_OK, wait_to_next(), 1'b1);
                  id_next++;
               end
            end
            KIND_CANCEL: begin
               for (int s = 0; s < CAPACITY && slot < 0; s++)
                  if (live[s] && tmr_id[s] == cancel_id) slot = s;
               if (slot < 0) begin
                  queue_response(1'b0, '0, STATUS_NOT_FOUND, wait_to_next(), 1'b1);
               end else begin
                  live[slot] = 1'b0;
                  count--;
                  queue_response(1'b0, '0, STATUS_OK, wait_to_next(), 1'b1);
               end
            end
            KIND_TICK: begin
               now_ms++;
               // pop expired timers in due order
               slot = earliest_slot();
               while (slot >= 0) begin
                  d = deadline[slot] - now_ms;
                  if (d != 0 && !d[31]) break;
                  queue_response(1'b1, tmr_id[slot], STATUS_OK, '0, 1'b0);
                  live[slot] = 1'b0;
                  count--;
                  slot = earliest_slot();
               end
               queue_response(1'b0, '0, STATUS_OK, wait_to_next(), 1'b1);
            end
            default: begin
               queue_response(1'b0, '0, STATUS_OK, wait_to_next(), 1'b1);
            end
         endcase
      endfunction

      // compare one observed response against the oldest one owed
      function void check_response(logic fired, logic [ID_BITS-1:0] id, logic [1:0] status,
                                   logic signed [WAIT_BITS:0] wait_ms, logic last);
         timer_response_type want;
         if (pending_responses.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected response fired %0b id %0d status %0d next %0d last %0b",
                        $time, fired, id, status, wait_ms, last);
            return;
         end
         want = pending_responses.pop_front();
         if (fired !== want.fired || id !== want.id || status !== want.status ||
             wait_ms !== want.next_timeout || last !== want.last) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: mismatch expected fired %0b id %0d status %0d next %0d last %0b",
                        $time, want.fired, want.id, want.status, want.next_timeout, want.last,
                        " / actual fired %0b id %0d status %0d next %0d last %0b",
                        fired, id, status, wait_ms, last);
         end
      endfunction

      function logic [ID_BITS-1:0] pick_live_id();
         int slots [$];
         for (int s = 0; s < CAPACITY; s++) if (live[s]) slots.push_back(s);
         if (slots.size() == 0) return ID_BITS'($urandom);
         return tmr_id[slots[$urandom_range(0, slots.size() - 1)]];
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_kind;
   logic [WAIT_BITS-1:0]         req_timeout;
   logic [ID_BITS-1:0]           req_cancel_id;
   logic                         rsp_valid;
   logic                         rsp_fired;
   logic [ID_BITS-1:0]           rsp_result_id;
   logic [1:0]                   rsp_status;
   logic signed [WAIT_BITS:0]    rsp_next_timeout;
   logic                         rsp_last;

   timer_scoreboard_type tracker;
   int                   cycle_count = 0;

   timer_min_heap_lazy_cancel dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_timeout(req_timeout),
      .req_cancel_id(req_cancel_id),
      .rsp_valid(rsp_valid),
      .rsp_fired(rsp_fired),
      .rsp_result_id(rsp_result_id),
      .rsp_status(rsp_status),
      .rsp_next_timeout(rsp_next_timeout),
      .rsp_last(rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_response(rsp_fired, rsp_result_id, rsp_status, rsp_next_timeout, rsp_last);
   end

   // present one request and hold it until the block takes it
   task automatic send_request(input logic [1:0] kind, input logic [WAIT_BITS-1:0] timeout,
                               input logic [ID_BITS-1:0] cancel_id);
      @(negedge clock);
      start         <= 1'b1;
      req_kind      <= kind;
      req_timeout   <= timeout;
      req_cancel_id <= cancel_id;
      do @(posedge clock); while (busy);
      tracker.note_request(kind, timeout, cancel_id);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending_responses.size() != 0) @(posedge clock);
   endtask

   // random request, weighted toward live ids and short timeouts so timers fire
   task automatic random_request();
      int                   pick, sel;
      logic [1:0]           kind;
      logic [WAIT_BITS-1:0] timeout;
      logic [ID_BITS-1:0]   cid;
      pick    = $urandom_range(0, 99);
      sel     = $urandom_range(0, 99);
      timeout = WAIT_BITS'($urandom);
      cid     = ID_BITS'($urandom);
      if (pick < 38) begin
         kind = KIND_TICK;
      end else if (pick < 72) begin
         kind = KIND_ADD;
         if (sel < 70) timeout = WAIT_BITS'($urandom_range(0, 12));
         else if (sel < 85) timeout = WAIT_BITS'($urandom_range(0, 200));
      end else if (pick < 96) begin
         kind = KIND_CANCEL;
         if (sel < 70) cid = tracker.pick_live_id();
         else if (sel < 85) cid = tracker.id_next - ID_BITS'($urandom_range(1, 40));
      end else begin
         kind = KIND_UNUSED;
      end
      send_request(kind, timeout, cid);
   endtask

   // fill the table, hit the full case once, then fire every timer on one tick
   task automatic fill_table();
      while (tracker.count < CAPACITY)
         send_request(KIND_ADD, WAIT_BITS'($urandom_range(0, 1)), ID_BITS'($urandom));
      send_request(KIND_ADD, WAIT_BITS'($urandom), ID_BITS'($urandom));
      send_request(KIND_TICK, '0, '0);
      send_request(KIND_TICK, '0, '0);
   endtask

   // stimulus
   initial begin
      int  sent;
      int  burst;
      bit  paused;
      tracker       = new();
      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_ADD;
      req_timeout   = '0;
      req_cancel_id = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, unused kind, ties, extremes, unknown ids
      send_request(KIND_TICK, '0, '0);
      send_request(KIND_CANCEL, '0, '0);
      send_request(KIND_UNUSED, '0, '0);
      send_request(KIND_ADD, '0, '0);
      send_request(KIND_ADD, MAX_TIMEOUT, '0);
      send_request(KIND_ADD, 24'd1, '0);
      send_request(KIND_ADD, 24'd1, '1);
      send_request(KIND_ADD, 24'd2, '0);
      send_request(KIND_TICK, '1, '1);
      send_request(KIND_CANCEL, '0, 16'd1);
      send_request(KIND_CANCEL, '0, 16'd1);
      send_request(KIND_CANCEL, '1, '1);
      send_request(KIND_ADD, MAX_TIMEOUT, '1);
      send_request(KIND_UNUSED, '1, '1);
      send_request(KIND_TICK, '0, '0);
      send_request(KIND_CANCEL, '0, 16'd5);
      send_request(KIND_TICK, '0, '0);
      wait_for_responses();

      fill_table();

      // random requests in bursts with gaps, one full drain halfway
      sent   = 0;
      paused = 1'b0;
      while (sent < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
            random_request();
            sent++;
         end
         if (!paused && sent >= RANDOM_REQUESTS / 2) begin
            wait_for_responses();
            paused = 1'b1;
         end else if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 8));
         end
      end

      // drain and settle
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.error_count == 0 && tracker.pending_responses.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
